FILE: src/assert_macros.svh
// Assertion macros for the checker of the TLB fill and invalidate unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TFI_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TFI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TFI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tfi_pkg.sv
// Package with the shared types and constants of the TLB fill and invalidate unit.
package tfi_pkg;

    localparam int PAGE_W        = 20;
    localparam int FRAME_W       = 20;
    localparam int SLOT_W        = 6;
    localparam int DEF_ENTRIES   = 64;
    localparam int DEF_PAGE_BITS = 20;

    typedef enum logic {
        OP_INSERT     = 1'b0,
        OP_INVALIDATE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Flags kept per entry in flip-flops.
    typedef struct packed {
        logic valid;
        logic writable;
    } entry_flags_t;

    // Write command to the flag file.
    typedef struct packed {
        logic en;
        logic valid;
        logic writable;
    } flag_wr_t;

endpackage

FILE: src/tfi_entry_ram.sv
// Synchronous entry memory holding the page and frame numbers of every slot.
module tfi_entry_ram #(
    parameter int DEPTH  = tfi_pkg::DEF_ENTRIES,
    parameter int DATA_W = tfi_pkg::PAGE_W + tfi_pkg::FRAME_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/tfi_flag_file.sv
// Per-slot valid and writable flags in flip-flops, cleared at reset, with a registered read port.
module tfi_flag_file #(
    parameter int DEPTH  = tfi_pkg::DEF_ENTRIES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_idx,
    output tfi_pkg::entry_flags_t rd_flags,
    input  tfi_pkg::flag_wr_t     wr_cmd,
    input  logic [ADDR_W-1:0]     wr_idx
);

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] writable_reg;
    tfi_pkg::entry_flags_t rd_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            writable_reg <= '0;
        end else if (wr_cmd.en) begin
            valid_reg[wr_idx]    <= wr_cmd.valid;
            writable_reg[wr_idx] <= wr_cmd.writable;
        end
    end

    // Registered read, like the entry memory, so both line up at the compare.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_flags_reg <= '0;
        end else if (rd_en) begin
            rd_flags_reg.valid    <= valid_reg[rd_idx];
            rd_flags_reg.writable <= writable_reg[rd_idx];
        end
    end

    assign rd_flags = rd_flags_reg;

endmodule

FILE: src/tlb_fill_and_invalidate_unit.sv
// TLB entry store: insert with round-robin replacement, invalidate by page.
// The scan reads one slot a cycle through the single read port of the entry memory and
// stops at the first matching slot or at the last slot; the result is then registered in
// the output stage once that stage is free.
// One item at a time: the next transfer is taken only once the result is loaded.
// Reset clears all valid and writable flags, the victim pointer and the output valid flag.
module tlb_fill_and_invalidate_unit #(
    parameter int TLB_ENTRIES      = tfi_pkg::DEF_ENTRIES,
    parameter int PAGE_NUMBER_BITS = tfi_pkg::DEF_PAGE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [tfi_pkg::PAGE_W-1:0]  s_page_number,
    input  logic [tfi_pkg::FRAME_W-1:0] s_frame_number,
    input  logic                        s_read_only,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tfi_pkg::SLOT_W-1:0]  m_slot_index,
    output logic                        m_replaced,
    output logic                        m_hit
);

    // Slot index width and the number of page bits that are actually kept. Page bits
    // above PAGE_NUMBER_BITS are ignored, and the port never carries more than PAGE_W.
    localparam int IDX_W  = $clog2(TLB_ENTRIES);
    localparam int KEEP_W = (PAGE_NUMBER_BITS < tfi_pkg::PAGE_W) ?
                            PAGE_NUMBER_BITS : tfi_pkg::PAGE_W;
    localparam int WORD_W = KEEP_W + tfi_pkg::FRAME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    // Sequencer state.
    tfi_pkg::state_t state_reg, state_next;

    // Captured request.
    tfi_pkg::opcode_t    op_reg;
    logic [KEEP_W-1:0]   page_reg;
    logic [tfi_pkg::FRAME_W-1:0] frame_reg;
    logic                ro_reg;

    // Scan pipeline: one slot address is issued to the memory per cycle, and the
    // slot issued in the previous cycle is compared against the request.
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg;

    // Outcome of the scan.
    logic             found_reg;
    logic [IDX_W-1:0] target_reg;

    // Round-robin victim pointer, advanced only on a replacement.
    logic [IDX_W-1:0] victim_reg, victim_next;

    // Output stage.
    logic                       m_valid_reg, m_valid_next;
    logic [tfi_pkg::SLOT_W-1:0] m_slot_reg;
    logic                       m_replaced_reg;
    logic                       m_hit_reg;

    // Control decoded from the state.
    logic issue;
    logic finish_go;

    // Datapath signals.
    logic [WORD_W-1:0]        rd_word;
    logic [KEEP_W-1:0]        rd_page;
    tfi_pkg::entry_flags_t    rd_flags;
    logic                     is_insert;
    logic                     match;
    logic                     scan_end;
    logic [IDX_W-1:0]         wr_slot;
    logic                     ram_we;
    tfi_pkg::flag_wr_t        flag_cmd;
    logic [IDX_W+tfi_pkg::SLOT_W-1:0] slot_ext;
    logic [tfi_pkg::SLOT_W-1:0]       slot_out;

    // The memory is written only in the finish state and read only during the scan,
    // so a read and a write of the same slot never overlap and no forwarding is needed.
    tfi_entry_ram #(
        .DEPTH  (TLB_ENTRIES),
        .DATA_W (WORD_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_word),
        .wr_en   (ram_we),
        .wr_addr (wr_slot),
        .wr_data ({page_reg, frame_reg})
    );

    // The flags are read on the same schedule as the memory, so both reach the
    // compare together in the cycle after the slot is issued.
    tfi_flag_file #(
        .DEPTH  (TLB_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_flags (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (issue),
        .rd_idx   (scan_idx_reg),
        .rd_flags (rd_flags),
        .wr_cmd   (flag_cmd),
        .wr_idx   (wr_slot)
    );

    assign rd_page   = rd_word[WORD_W-1 -: KEEP_W];
    assign is_insert = (op_reg == tfi_pkg::OP_INSERT);

    // An insert stops at the first free slot; an invalidate stops at the first valid
    // slot holding the page. Flags do not change during a scan, so the compare sees
    // the same store that the request found on arrival.
    always_comb begin
        if (is_insert) begin
            match = cmp_vld_reg && !rd_flags.valid;
        end else begin
            match = cmp_vld_reg && rd_flags.valid && (rd_page == page_reg);
        end
        scan_end = (state_reg == tfi_pkg::ST_SCAN) && cmp_vld_reg &&
                   (match || (cmp_idx_reg == LAST_IDX));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tfi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tfi_pkg::ST_SCAN;
                end
            end
            tfi_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = tfi_pkg::ST_FINISH;
                end
            end
            tfi_pkg::ST_FINISH: begin
                if (finish_go) begin
                    state_next = tfi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tfi_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs. The finish step waits only for the output register to be free,
    // so a new request can be taken while the previous result still waits.
    always_comb begin
        s_ready   = 1'b0;
        issue     = 1'b0;
        finish_go = 1'b0;
        case (state_reg)
            tfi_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            tfi_pkg::ST_SCAN: begin
                issue = !issue_done_reg;
            end
            tfi_pkg::ST_FINISH: begin
                finish_go = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Commit: an insert that found no free slot takes the victim slot.
    always_comb begin
        wr_slot = (is_insert && !found_reg) ? victim_reg : target_reg;
        ram_we  = finish_go && is_insert;

        flag_cmd.en       = finish_go && (is_insert || found_reg);
        flag_cmd.valid    = is_insert;
        flag_cmd.writable = is_insert && !ro_reg;

        if (finish_go && is_insert && !found_reg) begin
            victim_next = (victim_reg == LAST_IDX) ? '0 : victim_reg + 1'b1;
        end else begin
            victim_next = victim_reg;
        end

        // A missed invalidate reports slot zero.
        slot_ext = {{tfi_pkg::SLOT_W{1'b0}}, wr_slot};
        slot_out = (is_insert || found_reg) ? slot_ext[tfi_pkg::SLOT_W-1:0] : '0;
    end

    // Scan counters.
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        if (s_valid && s_ready) begin
            scan_idx_next   = '0;
            issue_done_next = 1'b0;
        end else if (issue) begin
            if (scan_idx_reg == LAST_IDX) begin
                issue_done_next = 1'b1;
            end else begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end
        cmp_vld_next = issue;
    end

    always_comb begin
        if (finish_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tfi_pkg::ST_IDLE;
            issue_done_reg <= 1'b1;
            cmp_vld_reg    <= 1'b0;
            victim_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            victim_reg     <= victim_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= tfi_pkg::opcode_t'(s_opcode);
            page_reg  <= s_page_number[KEEP_W-1:0];
            frame_reg <= s_frame_number;
            ro_reg    <= s_read_only;
        end
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= scan_idx_reg;
        if (scan_end) begin
            found_reg  <= match;
            target_reg <= cmp_idx_reg;
        end
        if (finish_go) begin
            m_slot_reg     <= slot_out;
            m_replaced_reg <= is_insert && !found_reg;
            m_hit_reg      <= is_insert || found_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_index = m_slot_reg;
    assign m_replaced   = m_replaced_reg;
    assign m_hit        = m_hit_reg;

endmodule

FILE: src/tfi_checker.sv
// Port-level checker for the TLB fill and invalidate unit, with its bind statement.
`include "assert_macros.svh"

module tfi_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [tfi_pkg::SLOT_W-1:0] m_slot_index,
    input logic                       m_replaced,
    input logic                       m_hit
);

    // A stalled result keeps its payload.
    `TFI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_slot_index) && $stable(m_replaced) && $stable(m_hit), "stalled result changed")

    // A replacement is always an insert, and an insert always reports a hit.
    `TFI_ASSERT(a_replace_hit, !m_valid || !m_replaced || m_hit, "replacement without hit")

    // A miss reports slot zero and no replacement.
    `TFI_ASSERT_IMPL(a_miss_zero, m_valid && !m_hit, (m_slot_index == '0) && !m_replaced, "miss result not zero")

    // The unit works on one request at a time: after a transfer it is busy.
    `TFI_ASSERT_NEXT(a_busy_after_take, s_valid && s_ready, !s_ready, "request taken while busy")

endmodule

bind tlb_fill_and_invalidate_unit tfi_checker u_tfi_checker (.*);
